// ===== sv/mpwp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the mesh packet wire parser: parse phases, status codes,
// register indexes, field widths and the packed result word.
// Depends on nothing; every other file of the block imports it.
package mpwp_pkg;

    // Parse phase. The encoding doubles as the field kind of a result word.
    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_TRANSPORT = 3'd1,
        PH_PATHLEN   = 3'd2,
        PH_PATH      = 3'd3,
        PH_PAYLOAD   = 3'd4,
        PH_BEYOND    = 3'd5
    } phase_t;

    // Validation status reported on the final byte of a packet.
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_LONG         = 3'd2,
        ST_CUT          = 3'd3,
        ST_BAD_PATH     = 3'd4,
        ST_NO_PAYLOAD   = 3'd5,
        ST_PAYLOAD_LONG = 3'd6
    } status_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOD_ROUTE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECT_ROUTE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PATH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PACKET   = 3'd4;

    // Register reset values.
    localparam logic [1:0] RST_FLOOD_ROUTE  = 2'd0;
    localparam logic [1:0] RST_DIRECT_ROUTE = 2'd3;
    localparam logic [7:0] RST_MAX_PATH     = 8'd64;
    localparam logic [7:0] RST_MAX_PAYLOAD  = 8'd184;
    localparam logic [8:0] RST_MAX_PACKET   = 9'd255;

    // Counter limits and format constants.
    localparam logic [9:0] BYTE_COUNT_MAX    = 10'd1023;
    localparam logic [8:0] PAYLOAD_COUNT_MAX = 9'd511;
    localparam logic [9:0] MIN_PACKET_BYTES  = 10'd3;
    localparam logic [2:0] BAD_HASH_SIZE     = 3'd4;
    localparam logic [1:0] LAST_CODE_BYTE    = 2'd3;

    // One result word as held in the output register.
    typedef struct packed {
        logic [7:0]  byte_out;
        phase_t      field_kind;
        logic [1:0]  route;
        logic [3:0]  packet_type;
        logic [1:0]  version;
        logic [2:0]  hash_bytes;
        logic [5:0]  hop_count;
        logic [15:0] transport_code_first;
        logic [15:0] transport_code_second;
        logic [8:0]  payload_length;
        logic        packet_end;
        status_t     status;
    } result_t;

endpackage

// ===== sv/mpwp_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the mesh packet wire parser: input bytes,
// result words and configuration writes. Depends on mpwp_pkg.
interface mpwp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface mpwp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic [2:0]  field_kind;
    logic [1:0]  route;
    logic [3:0]  packet_type;
    logic [1:0]  version;
    logic [2:0]  hash_bytes;
    logic [5:0]  hop_count;
    logic [15:0] transport_code_first;
    logic [15:0] transport_code_second;
    logic [8:0]  payload_length;
    logic        packet_end;
    logic [2:0]  status;

    modport source (
        output valid, output byte_out, output field_kind, output route,
        output packet_type, output version, output hash_bytes, output hop_count,
        output transport_code_first, output transport_code_second,
        output payload_length, output packet_end, output status,
        input ready
    );
    modport sink (
        input valid, input byte_out, input field_kind, input route,
        input packet_type, input version, input hash_bytes, input hop_count,
        input transport_code_first, input transport_code_second,
        input payload_length, input packet_end, input status,
        output ready
    );
endinterface

interface mpwp_cfg_if
    import mpwp_pkg::*;
    ;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/mesh_packet_wire_parser.sv =====
`timescale 1ns / 1ps
// Top level of the mesh packet wire parser: input register, field decode
// and checks, packet state and result register. Depends on mpwp_pkg, mpwp_if.
//
//  channel      direction  word                        handshake
//  in_chan      sink       byte_in, last_byte          valid/ready
//  out_chan     source     decoded fields and status   valid/ready
//  cfg_chan     sink       index, data                 valid/ready (ready always high)
//
// One byte per cycle unless out_chan stalls: an accepted byte sits in the input
// register, and the decode and state update load its result into the result
// register, which offers it on out_chan. The input register takes a new byte
// while a result waits; only when both hold a word and out_chan ready is low
// does in_chan ready drop. Reset clears the packet state, the registers to
// their defaults and both valid flags.
module mesh_packet_wire_parser
    import mpwp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mpwp_in_if.sink      in_chan,
    mpwp_out_if.source   out_chan,
    mpwp_cfg_if.sink     cfg_chan
);

    // Configuration registers.
    logic [1:0] flood_route_reg;
    logic [1:0] direct_route_reg;
    logic [7:0] max_path_reg;
    logic [7:0] max_payload_reg;
    logic [8:0] max_packet_reg;

    // Input register.
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Packet state.
    phase_t      phase_reg, phase_next;
    logic [9:0]  byte_count_reg, byte_count_next;
    logic [7:0]  header_reg, header_next;
    logic [1:0]  code_index_reg, code_index_next;
    logic [15:0] code_first_reg, code_first_next;
    logic [15:0] code_second_reg, code_second_next;
    logic [7:0]  path_len_reg, path_len_next;
    logic [7:0]  path_left_reg, path_left_next;
    logic [8:0]  payload_count_reg, payload_count_next;
    logic        bad_path_reg, bad_path_next;

    // Output register.
    logic    out_vld_reg;
    result_t out_reg, out_next;

    // Decode helpers.
    logic       advance;
    logic [1:0] hdr_route;
    logic [2:0] pl_hash_bytes;
    logic [5:0] pl_hop_count;
    logic [8:0] pl_path_bytes;
    logic [7:0] path_left_dec;
    status_t    status_next;

    assign advance       = in_vld_reg && (!out_vld_reg || out_chan.ready);
    assign in_chan.ready = !in_vld_reg || advance;
    assign cfg_chan.ready = 1'b1;

    // Configuration writes; writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flood_route_reg  <= RST_FLOOD_ROUTE;
            direct_route_reg <= RST_DIRECT_ROUTE;
            max_path_reg     <= RST_MAX_PATH;
            max_payload_reg  <= RST_MAX_PAYLOAD;
            max_packet_reg   <= RST_MAX_PACKET;
        end
        else if (cfg_chan.valid)
        begin
            case (cfg_chan.index)
                CFG_FLOOD_ROUTE:  flood_route_reg  <= cfg_chan.data[1:0];
                CFG_DIRECT_ROUTE: direct_route_reg <= cfg_chan.data[1:0];
                CFG_MAX_PATH:     max_path_reg     <= cfg_chan.data[7:0];
                CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_chan.data[7:0];
                CFG_MAX_PACKET:   max_packet_reg   <= cfg_chan.data[8:0];
                default:          ;
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_chan.ready)
        begin
            in_vld_reg <= in_chan.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_chan.valid && in_chan.ready)
        begin
            in_byte_reg <= in_chan.byte_in;
            in_last_reg <= in_chan.last_byte;
        end
    end

    // Path length decode: hash size, hop count and total path bytes.
    assign hdr_route     = in_byte_reg[1:0];
    assign pl_hash_bytes = {1'b0, in_byte_reg[7:6]} + 3'd1;
    assign pl_hop_count  = in_byte_reg[5:0];
    assign pl_path_bytes = 9'(pl_hop_count) * 9'(pl_hash_bytes);
    assign path_left_dec = (path_left_reg != 8'd0) ? path_left_reg - 8'd1 : path_left_reg;

    // Phase step for the byte in the input register.
    always_comb
    begin
        phase_next         = phase_reg;
        byte_count_next    = (byte_count_reg != BYTE_COUNT_MAX) ? byte_count_reg + 10'd1
                                                                : byte_count_reg;
        header_next        = header_reg;
        code_index_next    = code_index_reg;
        code_first_next    = code_first_reg;
        code_second_next   = code_second_reg;
        path_len_next      = path_len_reg;
        path_left_next     = path_left_reg;
        payload_count_next = payload_count_reg;
        bad_path_next      = bad_path_reg;

        case (phase_reg)
            PH_HEADER:
            begin
                header_next     = in_byte_reg;
                code_index_next = 2'd0;
                if (hdr_route == flood_route_reg || hdr_route == direct_route_reg)
                    phase_next = PH_TRANSPORT;
                else
                    phase_next = PH_PATHLEN;
            end
            PH_TRANSPORT:
            begin
                case (code_index_reg)
                    2'd0:    code_first_next  = {code_first_reg[15:8], in_byte_reg};
                    2'd1:    code_first_next  = {in_byte_reg, code_first_reg[7:0]};
                    2'd2:    code_second_next = {code_second_reg[15:8], in_byte_reg};
                    default: code_second_next = {in_byte_reg, code_second_reg[7:0]};
                endcase
                code_index_next = code_index_reg + 2'd1;
                if (code_index_reg == LAST_CODE_BYTE)
                    phase_next = PH_PATHLEN;
            end
            PH_PATHLEN:
            begin
                path_len_next = in_byte_reg;
                if (pl_hash_bytes >= BAD_HASH_SIZE || pl_path_bytes > {1'b0, max_path_reg})
                begin
                    bad_path_next = 1'b1;
                    phase_next    = PH_BEYOND;
                end
                else
                begin
                    path_left_next = pl_path_bytes[7:0];
                    phase_next     = (pl_path_bytes != 9'd0) ? PH_PATH : PH_PAYLOAD;
                end
            end
            PH_PATH:
            begin
                path_left_next = path_left_dec;
                if (path_left_dec == 8'd0)
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (payload_count_reg != PAYLOAD_COUNT_MAX)
                    payload_count_next = payload_count_reg + 9'd1;
            end
            default:
            begin
                phase_next = PH_BEYOND;
            end
        endcase
    end

    // Validation status on the final byte, in priority order.
    always_comb
    begin
        status_next = ST_OK;
        if (in_last_reg)
        begin
            if (byte_count_next < MIN_PACKET_BYTES)
                status_next = ST_SHORT;
            else if (byte_count_next > {1'b0, max_packet_reg})
                status_next = ST_LONG;
            else if (bad_path_next || phase_next == PH_BEYOND)
                status_next = ST_BAD_PATH;
            else if (phase_next inside {PH_TRANSPORT, PH_PATHLEN, PH_HEADER})
                status_next = ST_CUT;
            else if (phase_next == PH_PATH || payload_count_next == 9'd0)
                status_next = ST_NO_PAYLOAD;
            else if (payload_count_next > {1'b0, max_payload_reg})
                status_next = ST_PAYLOAD_LONG;
            else
                status_next = ST_OK;
        end
    end

    // Result word from the updated state.
    always_comb
    begin
        out_next.byte_out              = in_byte_reg;
        out_next.field_kind            = phase_reg;
        out_next.route                 = header_next[1:0];
        out_next.packet_type           = header_next[5:2];
        out_next.version               = header_next[7:6];
        out_next.hash_bytes            = {1'b0, path_len_next[7:6]} + 3'd1;
        out_next.hop_count             = path_len_next[5:0];
        out_next.transport_code_first  = code_first_next;
        out_next.transport_code_second = code_second_next;
        out_next.payload_length        = payload_count_next;
        out_next.packet_end            = in_last_reg;
        out_next.status                = status_next;
    end

    // Packet state: step on each byte, clear after the final one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            byte_count_reg    <= 10'd0;
            header_reg        <= 8'd0;
            code_index_reg    <= 2'd0;
            code_first_reg    <= 16'd0;
            code_second_reg   <= 16'd0;
            path_len_reg      <= 8'd0;
            path_left_reg     <= 8'd0;
            payload_count_reg <= 9'd0;
            bad_path_reg      <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                phase_reg         <= PH_HEADER;
                byte_count_reg    <= 10'd0;
                header_reg        <= 8'd0;
                code_index_reg    <= 2'd0;
                code_first_reg    <= 16'd0;
                code_second_reg   <= 16'd0;
                path_len_reg      <= 8'd0;
                path_left_reg     <= 8'd0;
                payload_count_reg <= 9'd0;
                bad_path_reg      <= 1'b0;
            end
            else
            begin
                phase_reg         <= phase_next;
                byte_count_reg    <= byte_count_next;
                header_reg        <= header_next;
                code_index_reg    <= code_index_next;
                code_first_reg    <= code_first_next;
                code_second_reg   <= code_second_next;
                path_len_reg      <= path_len_next;
                path_left_reg     <= path_left_next;
                payload_count_reg <= payload_count_next;
                bad_path_reg      <= bad_path_next;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || out_chan.ready)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // Output drive.
    assign out_chan.valid                 = out_vld_reg;
    assign out_chan.byte_out              = out_reg.byte_out;
    assign out_chan.field_kind            = out_reg.field_kind;
    assign out_chan.route                 = out_reg.route;
    assign out_chan.packet_type           = out_reg.packet_type;
    assign out_chan.version               = out_reg.version;
    assign out_chan.hash_bytes            = out_reg.hash_bytes;
    assign out_chan.hop_count             = out_reg.hop_count;
    assign out_chan.transport_code_first  = out_reg.transport_code_first;
    assign out_chan.transport_code_second = out_reg.transport_code_second;
    assign out_chan.payload_length        = out_reg.payload_length;
    assign out_chan.packet_end            = out_reg.packet_end;
    assign out_chan.status                = out_reg.status;

    // A nonzero status is only reported on the final byte.
    a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_reg.packet_end |-> out_reg.status == ST_OK)
        else $error("status reported on a byte that is not the final one");

    // After the final byte has advanced, the packet state is back at its start.
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> phase_reg == PH_HEADER && byte_count_reg == 10'd0
                                   && payload_count_reg == 9'd0 && !bad_path_reg)
        else $error("packet state not cleared after the final byte");

    // A final byte in the error phase reports size or bad path length only.
    a_beyond_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.packet_end && out_reg.field_kind == PH_BEYOND
        |-> out_reg.status == ST_SHORT || out_reg.status == ST_LONG
            || out_reg.status == ST_BAD_PATH)
        else $error("error phase byte ended with an unexpected status");

    // A byte held in the input register while the output stalls stays there.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_byte_reg)
                                   && $stable(in_last_reg))
        else $error("stalled input word lost");

endmodule

// ===== dv/mesh_packet_wire_parser_checker.sv =====
`timescale 1ns / 1ps
// Checker for the mesh packet wire parser: watches the byte, result and
// register channels, decodes every accepted byte on its own and compares.
// Depends on mpwp_pkg and the channel interfaces in mpwp_if.
module mesh_packet_wire_parser_checker
    import mpwp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mpwp_in_if   in_chan,
    mpwp_out_if  out_chan,
    mpwp_cfg_if  cfg_chan,
    output int   mismatch_count,
    output int   words_in_flight
);

    // Register copies, updated on every accepted register write.
    logic [1:0] flood_route;
    logic [1:0] direct_route;
    logic [7:0] path_cap;
    logic [7:0] payload_cap;
    logic [8:0] packet_cap;

    // Packet state of the decoder.
    phase_t      stage;
    logic [9:0]  seen_bytes;
    logic [7:0]  hdr_byte;
    logic [1:0]  code_pos;
    logic [15:0] code_a;
    logic [15:0] code_b;
    logic [7:0]  len_byte;
    logic [7:0]  path_left;
    logic [8:0]  payload_seen;
    logic        path_bad;

    // Result words predicted and not yet seen on the output.
    result_t decoded_words[$];

    function automatic void clear_packet();
        stage        = PH_HEADER;
        seen_bytes   = '0;
        hdr_byte     = '0;
        code_pos     = '0;
        code_a       = '0;
        code_b       = '0;
        len_byte     = '0;
        path_left    = '0;
        payload_seen = '0;
        path_bad     = 1'b0;
    endfunction

    // Decodes one raw byte: tags it, updates the packet state and, on the
    // final byte, works out the validation status.
    function automatic result_t decode_byte(input logic [7:0] b, input logic fin);
        result_t    r;
        logic [2:0] hs;
        int         prod;
        status_t    st;
        r.field_kind = stage;
        st = ST_OK;
        if (seen_bytes != BYTE_COUNT_MAX)
            seen_bytes = seen_bytes + 10'd1;

        case (stage)
            PH_HEADER:
            begin
                hdr_byte = b;
                code_pos = '0;
                stage = (b[1:0] == flood_route || b[1:0] == direct_route) ?
                        PH_TRANSPORT : PH_PATHLEN;
            end
            PH_TRANSPORT:
            begin
                // Two little-endian codes, low byte first.
                case (code_pos)
                    2'd0: code_a[7:0]  = b;
                    2'd1: code_a[15:8] = b;
                    2'd2: code_b[7:0]  = b;
                    default: code_b[15:8] = b;
                endcase
                if (code_pos == LAST_CODE_BYTE)
                begin
                    code_pos = '0;
                    stage = PH_PATHLEN;
                end
                else
                    code_pos = code_pos + 2'd1;
            end
            PH_PATHLEN:
            begin
                hs = {1'b0, b[7:6]} + 3'd1;
                prod = int'(b[5:0]) * int'(hs);
                len_byte = b;
                if (hs >= BAD_HASH_SIZE || prod > int'(path_cap))
                begin
                    path_bad = 1'b1;
                    stage = PH_BEYOND;
                end
                else
                begin
                    path_left = 8'(prod);
                    stage = (prod != 0) ? PH_PATH : PH_PAYLOAD;
                end
            end
            PH_PATH:
            begin
                if (path_left != 0)
                    path_left = path_left - 8'd1;
                if (path_left == 0)
                    stage = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (payload_seen != PAYLOAD_COUNT_MAX)
                    payload_seen = payload_seen + 9'd1;
            end
            default:
                stage = PH_BEYOND;
        endcase

        // Status checks in priority order.
        if (fin)
        begin
            if (seen_bytes < MIN_PACKET_BYTES)
                st = ST_SHORT;
            else if (seen_bytes > {1'b0, packet_cap})
                st = ST_LONG;
            else if (path_bad || stage == PH_BEYOND)
                st = ST_BAD_PATH;
            else if (stage == PH_HEADER || stage == PH_TRANSPORT || stage == PH_PATHLEN)
                st = ST_CUT;
            else if (stage == PH_PATH || payload_seen == 0)
                st = ST_NO_PAYLOAD;
            else if (payload_seen > {1'b0, payload_cap})
                st = ST_PAYLOAD_LONG;
        end

        r.byte_out              = b;
        r.route                 = hdr_byte[1:0];
        r.packet_type           = hdr_byte[5:2];
        r.version               = hdr_byte[7:6];
        r.hash_bytes            = {1'b0, len_byte[7:6]} + 3'd1;
        r.hop_count             = len_byte[5:0];
        r.transport_code_first  = code_a;
        r.transport_code_second = code_b;
        r.payload_length        = payload_seen;
        r.packet_end            = fin;
        r.status                = st;

        if (fin)
            clear_packet();
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // Register writes, result checks, then prediction of the byte taken
    // at this edge, so a result never meets its own prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            flood_route  = RST_FLOOD_ROUTE;
            direct_route = RST_DIRECT_ROUTE;
            path_cap     = RST_MAX_PATH;
            payload_cap  = RST_MAX_PAYLOAD;
            packet_cap   = RST_MAX_PACKET;
            clear_packet();
            decoded_words.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_chan.valid && cfg_chan.ready)
            begin
                case (cfg_chan.index)
                    CFG_FLOOD_ROUTE:  flood_route  = cfg_chan.data[1:0];
                    CFG_DIRECT_ROUTE: direct_route = cfg_chan.data[1:0];
                    CFG_MAX_PATH:     path_cap     = cfg_chan.data[7:0];
                    CFG_MAX_PAYLOAD:  payload_cap  = cfg_chan.data[7:0];
                    CFG_MAX_PACKET:   packet_cap   = cfg_chan.data[8:0];
                    default: ;
                endcase
            end

            if (out_chan.valid && out_chan.ready)
            begin
                if (decoded_words.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result word expected none actual byte %0d", $time,
                             out_chan.byte_out);
                end
                else
                begin
                    want = decoded_words.pop_front();
                    check_field("byte_out", want.byte_out, out_chan.byte_out);
                    check_field("field_kind", want.field_kind, out_chan.field_kind);
                    check_field("route", want.route, out_chan.route);
                    check_field("packet_type", want.packet_type, out_chan.packet_type);
                    check_field("version", want.version, out_chan.version);
                    check_field("hash_bytes", want.hash_bytes, out_chan.hash_bytes);
                    check_field("hop_count", want.hop_count, out_chan.hop_count);
                    check_field("transport_code_first", want.transport_code_first,
                                out_chan.transport_code_first);
                    check_field("transport_code_second", want.transport_code_second,
                                out_chan.transport_code_second);
                    check_field("payload_length", want.payload_length,
                                out_chan.payload_length);
                    check_field("packet_end", want.packet_end, out_chan.packet_end);
                    check_field("status", want.status, out_chan.status);
                end
            end

            if (in_chan.valid && in_chan.ready)
                decoded_words.push_back(decode_byte(in_chan.byte_in, in_chan.last_byte));
        end
        words_in_flight = decoded_words.size();
    end

endmodule

// ===== dv/mesh_packet_wire_parser_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the mesh packet wire parser: clock, reset, packet and
// register stimulus, output stalls and the verdict. Depends on mpwp_pkg,
// mpwp_if, the parser and mesh_packet_wire_parser_checker.
module mesh_packet_wire_parser_tb;
    import mpwp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 250;
    localparam int PHASES       = 6;
    localparam int IDLE_PCT     = 9;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   cycles = 0;
    int   mismatch_count;
    int   words_in_flight;
    int   bytes_sent;
    bit   calm;

    // Register values as last written, used to shape the packets.
    logic [1:0] flood_route;
    logic [1:0] direct_route;
    logic [7:0] path_cap;
    logic [7:0] payload_cap;
    logic [8:0] packet_cap;

    // Bytes of the packet about to be sent.
    logic [7:0] pkt_q[$];

    mpwp_in_if  in_if();
    mpwp_out_if out_if();
    mpwp_cfg_if cfg_if();

    mesh_packet_wire_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_if),
        .out_chan (out_if),
        .cfg_chan (cfg_if)
    );

    mesh_packet_wire_parser_checker parse_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_chan         (in_if),
        .out_chan        (out_if),
        .cfg_chan        (cfg_if),
        .mismatch_count  (mismatch_count),
        .words_in_flight (words_in_flight)
    );

    always #5 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("mesh_packet_wire_parser: mismatch");
            $finish;
        end
    end

    // Result side stalls at random, except during the calm stretch.
    initial
    begin
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Sends one word; valid stays high afterward so back-to-back words flow.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.byte_in   <= b;
        in_if.last_byte <= fin;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt_q[i])
            send_byte(pkt_q[i], i == pkt_q.size() - 1);
    endtask

    // Holds the input off until every predicted result word has come out.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (words_in_flight != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
    endtask

    // Writes all five registers while the parser is idle.
    task automatic configure(input logic [1:0] fr, input logic [1:0] dr,
                             input logic [7:0] mp, input logic [7:0] my,
                             input logic [8:0] mk);
        drain_results();
        flood_route  = fr;
        direct_route = dr;
        path_cap     = mp;
        payload_cap  = my;
        packet_cap   = mk;
        put_reg(CFG_FLOOD_ROUTE, {7'd0, fr});
        put_reg(CFG_DIRECT_ROUTE, {7'd0, dr});
        put_reg(CFG_MAX_PATH, {1'b0, mp});
        put_reg(CFG_MAX_PAYLOAD, {1'b0, my});
        put_reg(CFG_MAX_PACKET, mk);
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly well-formed packets with random content; some noise, some cut
    // short, some with a bad path length or a payload at the size limit.
    task automatic build_packet();
        int         sel;
        int         n;
        int         hs_code;
        int         hc;
        int         hc_top;
        int         pay_len;
        logic [1:0] rt;
        pkt_q.delete();
        if ($urandom_range(99) < 8)
        begin
            n = $urandom_range(1, 6);
            repeat (n) pkt_q.push_back(8'($urandom_range(255)));
            return;
        end

        if ($urandom_range(1))
            rt = $urandom_range(1) ? flood_route : direct_route;
        else
            rt = 2'($urandom_range(3));
        pkt_q.push_back({2'($urandom_range(3)), 4'($urandom_range(15)), rt});
        if (rt == flood_route || rt == direct_route)
            repeat (4) pkt_q.push_back(8'($urandom_range(255)));

        // Path length byte and the path hashes it announces.
        sel = $urandom_range(99);
        if (sel < 6)
            pkt_q.push_back({2'b11, 6'($urandom_range(63))});
        else if (sel < 14)
            pkt_q.push_back(8'($urandom_range(255)));
        else
        begin
            hs_code = $urandom_range(2);
            hc_top = int'(path_cap) / (hs_code + 1);
            if (hc_top > 63)
                hc_top = 63;
            if ($urandom_range(9) != 0 && hc_top > 4)
                hc_top = 4;
            hc = $urandom_range(hc_top);
            pkt_q.push_back({2'(hs_code), 6'(hc)});
            repeat (hc * (hs_code + 1)) pkt_q.push_back(8'($urandom_range(255)));
        end

        // Payload length, sometimes right at a size limit.
        sel = $urandom_range(99);
        if (sel < 8)
            pay_len = 0;
        else if (sel < 11)
            pay_len = int'(payload_cap) - 1 + int'($urandom_range(3));
        else if (sel < 15 && packet_cap <= 40)
        begin
            pay_len = int'(packet_cap) - pkt_q.size();
            pay_len += int'($urandom_range(1));
        end
        else
            pay_len = $urandom_range(1, 12);
        if (pay_len < 0)
            pay_len = 0;
        repeat (pay_len) pkt_q.push_back(8'($urandom_range(255)));

        if ($urandom_range(99) < 8)
        begin
            n = $urandom_range(1, pkt_q.size());
            while (pkt_q.size() > n)
                void'(pkt_q.pop_back());
        end
    endtask

    initial
    begin
        int base;
        in_if.valid     = 1'b0;
        in_if.byte_in   = '0;
        in_if.last_byte = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_FLOOD_ROUTE;
        cfg_if.data     = '0;
        calm            = 1'b0;
        bytes_sent      = 0;
        flood_route     = RST_FLOOD_ROUTE;
        direct_route    = RST_DIRECT_ROUTE;
        path_cap        = RST_MAX_PATH;
        payload_cap     = RST_MAX_PAYLOAD;
        packet_cap      = RST_MAX_PACKET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed packets under the reset register values: a lone header,
        // a two-byte packet, a cut transport section, a full transport packet,
        // hash size four, a missing payload and a path over the byte limit.
        pkt_q = {8'hFF};
        send_packet();
        pkt_q = {8'h00, 8'hFF};
        send_packet();
        pkt_q = {8'hFF, 8'h34, 8'h12};
        send_packet();
        pkt_q = {8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h41, 8'hAB, 8'hCD, 8'h5A};
        send_packet();
        pkt_q = {8'h01, 8'hC0, 8'hAA};
        send_packet();
        pkt_q = {8'h02, 8'h02, 8'h77};
        send_packet();
        pkt_q = {8'h06, 8'h7F, 8'h00};
        send_packet();

        // One packet long enough to saturate both the byte and payload counts,
        // sent as a long stretch with no idling on either side.
        pkt_q = {8'h05, 8'h00};
        repeat (1024) pkt_q.push_back(8'($urandom_range(255)));
        calm = 1'b1;
        send_packet();
        calm = 1'b0;

        // Random packets over several register settings, extremes included.
        base = bytes_sent;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: ;
                1: configure(2'd1, 2'd2, 8'd189, 8'd255, 9'd511);
                2: configure(2'd2, 2'd2, 8'd0, 8'd1, 9'd3);
                default:
                    configure(2'($urandom_range(3)), 2'($urandom_range(3)),
                              8'($urandom_range(189)), 8'($urandom_range(1, 255)),
                              9'($urandom_range(3, 511)));
            endcase
            calm = (p == 3);
            while (bytes_sent < base + RANDOM_BYTES * (p + 1) / PHASES)
            begin
                build_packet();
                send_packet();
                if ($urandom_range(99) < 2)
                    drain_results();
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && words_in_flight == 0)
            $display("mesh_packet_wire_parser: match");
        else
            $display("mesh_packet_wire_parser: mismatch");
        $finish;
    end

endmodule
